FILE: rtl/ksfl_pkg.sv
// Package for the shared-store stack block: operation codes, result status
// codes, back-end sequencer states and the flag group sent with each result.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ksfl_pkg;

    // Operation carried with each request.
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    // Status reported with each result.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_POP2
    } bk_state_t;

    // Flags that travel with each result value.
    typedef struct packed {
        logic    empty;
        logic    full;
        status_t status;
    } res_flags_t;

endpackage

`default_nettype wire

FILE: rtl/ksfl_front.sv
// Front end of the shared-store stack block: accepts requests, folds the
// stack number into range and queues the request for the back end.
// Depends on ksfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ksfl_front
    import ksfl_pkg::*;
#(
    parameter int NUM_STACKS = 4,
    parameter int DATA_WIDTH = 32,
    parameter int SW         = 2
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire op_t                   in_op,
    input  wire logic [1:0]            in_sid,
    input  wire logic [DATA_WIDTH-1:0] in_item,
    output      logic                  q_valid,
    input  wire logic                  q_pop,
    output      op_t                   q_op,
    output      logic [SW-1:0]         q_sid,
    output      logic [DATA_WIDTH-1:0] q_item
);

    // The stack number is two bits wide, so at most three subtractions
    // bring it below the stack count.
    function automatic logic [SW-1:0] fold_sid(input logic [1:0] raw);
        logic [6:0] v;
        v = 7'(raw);
        for (int k = 0; k < 3; k++) begin
            if (v >= 7'(NUM_STACKS))
            begin
                v = v - 7'(NUM_STACKS);
            end
        end
        return SW'(v);
    endfunction

    op_t                   ent_op   [2];
    logic [SW-1:0]         ent_sid  [2];
    logic [DATA_WIDTH-1:0] ent_item [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       push;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_op     = ent_op[rd_ptr_reg];
    assign q_sid    = ent_sid[rd_ptr_reg];
    assign q_item   = ent_item[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_op[wr_ptr_reg]   <= in_op;
            ent_sid[wr_ptr_reg]  <= fold_sid(in_sid);
            ent_item[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ksfl_back.sv
// Back end of the shared-store stack block: sequences pushes and pops over
// the head, link and data memories and holds the result register.
// Depends on ksfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ksfl_back
    import ksfl_pkg::*;
#(
    parameter int NUM_STACKS = 4,
    parameter int NUM_SLOTS  = 16,
    parameter int DATA_WIDTH = 32,
    parameter int SW         = 2
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    output      logic                  q_pop,
    input  wire op_t                   q_op,
    input  wire logic [SW-1:0]         q_sid,
    input  wire logic [DATA_WIDTH-1:0] q_item,
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      logic [DATA_WIDTH-1:0] out_value,
    output      res_flags_t            out_flags
);

    localparam int AW = $clog2(NUM_SLOTS);
    localparam int IW = $clog2(NUM_SLOTS + 1);
    localparam logic [IW-1:0] NULL_IDX = IW'(NUM_SLOTS);
    localparam logic [DATA_WIDTH-1:0] MAX_POS = {DATA_WIDTH{1'b1}} >> 1;

    // Memories. Link entries at or above the fill mark were never written
    // and read as the next slot, which rebuilds the initial free chain.
    logic [IW-1:0]         head_mem [NUM_STACKS];
    logic [IW-1:0]         link_mem [NUM_SLOTS];
    logic [DATA_WIDTH-1:0] data_mem [NUM_SLOTS];
    logic [NUM_STACKS-1:0] head_vld_reg;

    bk_state_t             state_reg, state_next;
    logic [IW-1:0]         free_head_reg, free_head_next;
    logic [IW-1:0]         fill_reg, fill_next;
    op_t                   op_reg;
    logic [SW-1:0]         sid_reg;
    logic [DATA_WIDTH-1:0] item_reg;
    logic [IW-1:0]         slot_reg, slot_next;
    logic [IW-1:0]         head_rd_reg;
    logic                  head_rd_vld_reg;
    logic [IW-1:0]         link_rd_reg;
    logic [DATA_WIDTH-1:0] data_rd_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] out_value_reg, out_value_next;
    res_flags_t            out_flags_reg, out_flags_next;

    logic          start;
    logic          out_load;
    logic [IW-1:0] head_now;
    logic [IW-1:0] next_free;
    logic [AW-1:0] link_raddr;
    logic          head_we, link_we, data_we;
    logic [IW-1:0] head_wdata, link_wdata;
    logic [AW-1:0] link_waddr;

    assign start     = (state_reg == BK_IDLE) && q_valid && (!out_valid_reg || out_ready);
    assign q_pop     = start;
    assign head_now  = head_rd_vld_reg ? head_rd_reg : NULL_IDX;
    assign next_free = (free_head_reg < fill_reg) ? link_rd_reg : free_head_reg + IW'(1);
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_flags = out_flags_reg;

    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        slot_next      = slot_reg;
        link_raddr     = AW'(free_head_reg);
        head_we        = 1'b0;
        head_wdata     = head_now;
        link_we        = 1'b0;
        link_waddr     = AW'(free_head_reg);
        link_wdata     = head_now;
        data_we        = 1'b0;
        out_load       = 1'b0;
        out_value_next = out_value_reg;
        out_flags_next = out_flags_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            BK_IDLE:
            begin
                if (start)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_IDLE;
                if (op_reg == OP_PUSH)
                begin
                    out_load       = 1'b1;
                    out_value_next = '0;
                    if (free_head_reg == NULL_IDX)
                    begin
                        out_flags_next = '{empty: (head_now == NULL_IDX), full: 1'b1,
                                           status: ST_OVERFLOW};
                    end
                    else
                    begin
                        link_we        = 1'b1;
                        head_we        = 1'b1;
                        head_wdata     = free_head_reg;
                        data_we        = 1'b1;
                        free_head_next = next_free;
                        if (free_head_reg == fill_reg)
                        begin
                            fill_next = fill_reg + IW'(1);
                        end
                        out_flags_next = '{empty: 1'b0, full: (next_free == NULL_IDX),
                                           status: ST_OK};
                    end
                end
                else if (head_now == NULL_IDX)
                begin
                    out_load       = 1'b1;
                    out_value_next = MAX_POS;
                    out_flags_next = '{empty: 1'b1, full: (free_head_reg == NULL_IDX),
                                       status: ST_UNDERFLOW};
                end
                else
                begin
                    // Fetch the link and value of the top slot.
                    slot_next  = head_now;
                    link_raddr = AW'(head_now);
                    state_next = BK_POP2;
                end
            end
            BK_POP2:
            begin
                state_next     = BK_IDLE;
                head_we        = 1'b1;
                head_wdata     = link_rd_reg;
                link_we        = 1'b1;
                link_waddr     = AW'(slot_reg);
                link_wdata     = free_head_reg;
                free_head_next = slot_reg;
                out_load       = 1'b1;
                out_value_next = data_rd_reg;
                out_flags_next = '{empty: (link_rd_reg == NULL_IDX), full: 1'b0,
                                   status: ST_OK};
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            free_head_reg   <= '0;
            fill_reg        <= '0;
            head_vld_reg    <= '0;
            head_rd_vld_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (start)
            begin
                head_rd_vld_reg <= head_vld_reg[q_sid];
            end
            if (head_we)
            begin
                head_vld_reg[sid_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        out_value_reg <= out_value_next;
        out_flags_reg <= out_flags_next;
        if (start)
        begin
            op_reg      <= q_op;
            sid_reg     <= q_sid;
            item_reg    <= q_item;
            head_rd_reg <= head_mem[q_sid];
        end
    end

    // Memory ports: one registered read and one write each.
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[sid_reg] <= head_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        link_rd_reg <= link_mem[link_raddr];
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        data_rd_reg <= data_mem[link_raddr];
        if (data_we)
        begin
            data_mem[AW'(free_head_reg)] <= item_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/k_stacks_shared_free_list.sv
// Sequence: a push accepted on an idle block passes from the queue through the request
// registers and the BK_READ state into the result register; a pop also passes through
// BK_POP2 before the result register, and m_tvalid rises when the result register loads.
// The back end takes no new request until the last one is done and the result register
// is free or being taken; a pop also waits for the link read that depends on the head read.
// Reset (asynchronous, active low) empties every stack, chains all slots into the
// free list and clears the queue and result register; no clearing pass is needed.
//
// Top level of several stacks kept in one shared slot store with one linked free
// list. Depends on ksfl_pkg, ksfl_front and ksfl_back.
`timescale 1ns / 1ps
`default_nettype none

module k_stacks_shared_free_list
    import ksfl_pkg::*;
#(
    parameter int NUM_STACKS = 4,
    parameter int NUM_SLOTS  = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Request channel.
    input  wire logic                                  s_tvalid,
    output      logic                                  s_tready,
    input  wire logic [((DATA_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // item
    input  wire logic [2:0]                            s_tuser,  // func, stack_id
    // Result channel.
    output      logic                                  m_tvalid,
    input  wire logic                                  m_tready,
    output      logic [((DATA_WIDTH + 7) / 8) * 8-1:0] m_tdata,  // value
    output      logic [3:0]                            m_tuser   // status[1:0], full_res,
                                                                 // empty_res
);

    localparam int TDW = ((DATA_WIDTH + 7) / 8) * 8;
    // Width of a folded stack number.
    localparam int SW  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    op_t                   q_op;
    logic [SW-1:0]         q_sid;
    logic [DATA_WIDTH-1:0] q_item;
    logic                  q_valid;
    logic                  q_pop;
    logic [DATA_WIDTH-1:0] out_value;
    res_flags_t            out_flags;

    // The front end takes requests and queues them; the queue lets the input
    // side keep accepting while the back end waits on a stalled result.
    ksfl_front #(
        .NUM_STACKS (NUM_STACKS),
        .DATA_WIDTH (DATA_WIDTH),
        .SW         (SW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (op_t'(s_tuser[0])),
        .in_sid   (s_tuser[2:1]),
        .in_item  (s_tdata[DATA_WIDTH-1:0]),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_op     (q_op),
        .q_sid    (q_sid),
        .q_item   (q_item)
    );

    // The back end walks the head, link and data memories one request at a
    // time and drives the result register.
    ksfl_back #(
        .NUM_STACKS (NUM_STACKS),
        .NUM_SLOTS  (NUM_SLOTS),
        .DATA_WIDTH (DATA_WIDTH),
        .SW         (SW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_op      (q_op),
        .q_sid     (q_sid),
        .q_item    (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (out_value),
        .out_flags (out_flags)
    );

    // Result value is zero-extended to whole bytes.
    assign m_tdata = TDW'(out_value);
    assign m_tuser = out_flags;

endmodule

`default_nettype wire

FILE: rtl/ksfl_checker.sv
// Port-level checker for the shared-store stack block, bound to the top level.
// Depends on ksfl_pkg and k_stacks_shared_free_list.
`timescale 1ns / 1ps
`default_nettype none

module ksfl_checker
    import ksfl_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  m_tvalid,
    input wire logic                                  m_tready,
    input wire logic [((DATA_WIDTH + 7) / 8) * 8-1:0] m_tdata,
    input wire logic [3:0]                            m_tuser
);

    localparam logic [DATA_WIDTH-1:0] MAX_POS = {DATA_WIDTH{1'b1}} >> 1;

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An underflow returns the largest positive value and an empty stack.
    a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] == ST_UNDERFLOW)
            |-> (m_tdata[DATA_WIDTH-1:0] == MAX_POS) && m_tuser[3])
        else $error("bad underflow result");

    // An overflow only happens with a full store and returns zero.
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] == ST_OVERFLOW)
            |-> m_tuser[2] && (m_tdata == '0))
        else $error("bad overflow result");

    // No result right after reset.
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind k_stacks_shared_free_list ksfl_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_ksfl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
